/* hdl/bga_pkg.sv */
package bga_pkg;

  // Built limits
  localparam int MaxLen   = 1024;
  localparam int MaxBand  = 256;
  localparam int Alphabet = 15;
  localparam int RowDepth = MaxBand + 3;

  // Field widths
  localparam int ReqW    = 2;
  localparam int LenW    = 11;
  localparam int SymW    = 4;
  localparam int TblW    = 16;
  localparam int BandW   = 12;
  localparam int ScoreW  = 32;
  localparam int CfgW    = 16;

  // Internal widths
  localparam int AccW     = 40;
  localparam int DiagW    = 14;
  localparam int RowIdxW  = $clog2(RowDepth);
  localparam int SeqAddrW = $clog2(MaxLen);
  localparam int TblAddrW = 2 * SymW;
  localparam int TblDepth = 1 << TblAddrW;
  localparam int CfgIdxW  = 1;

  localparam logic signed [AccW-1:0] NegFloor = -40'sd999999999;

  typedef enum logic [ReqW-1:0] {
    REQ_TABLE  = 2'd0,
    REQ_LOAD_A = 2'd1,
    REQ_LOAD_B = 2'd2,
    REQ_START  = 2'd3
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAP_OPEN   = 1'b0,
    CFG_GAP_EXTEND = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ReqW-1:0]         req_type;
    logic [LenW-1:0]         position;
    logic [SymW-1:0]         symbol;
    logic [SymW-1:0]         table_row;
    logic [SymW-1:0]         table_col;
    logic signed [TblW-1:0]  table_value;
    logic [LenW-1:0]         len_a;
    logic [LenW-1:0]         len_b;
    logic signed [BandW-1:0] band_low;
    logic signed [BandW-1:0] band_high;
  } req_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic                     status;
  } result_t;

  // Clamped band and length check
  typedef struct packed {
    logic                     oversize;
    logic signed [DiagW-1:0]  low;
    logic signed [DiagW-1:0]  up;
    logic signed [DiagW-1:0]  band;
  } clamp_t;

  // Operands of one matrix cell
  typedef struct packed {
    logic signed [AccW-1:0] sk;
    logic signed [AccW-1:0] s1;
    logic signed [AccW-1:0] g1;
    logic signed [AccW-1:0] cprev;
    logic signed [AccW-1:0] e;
    logic signed [AccW-1:0] sub;
    logic signed [AccW-1:0] g;
    logic signed [AccW-1:0] h;
    logic signed [AccW-1:0] m;
    logic                   first;
    logic                   col_ok;
  } cell_in_t;

  typedef struct packed {
    logic signed [AccW-1:0] c;
    logic signed [AccW-1:0] d;
    logic signed [AccW-1:0] e;
  } cell_out_t;

endpackage

/* hdl/banded_affine_gap_alignment_score_core.sv */
// Load beats (table write, symbol load) give no result.
// A start beat gives one result: it ends early for oversize, empty sequences or too wide bands,
// runs along a single diagonal, or sweeps the band row by row through the one cell unit.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset clears control state and gap registers; table, symbol and row stores stay undefined.
module banded_affine_gap_alignment_score_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bga_pkg::req_t                 req_i,
  output logic                          done_o,
  output bga_pkg::result_t              result_o,
  input  logic                          cfg_we_i,
  input  logic [bga_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bga_pkg::CfgW-1:0]      cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_INIT, S_ROW, S_RDK, S_RD, S_TB, S_CMP, S_DRD, S_DTB, S_DACC
  } state_e;

  localparam int AccW  = bga_pkg::AccW;
  localparam int DiagW = bga_pkg::DiagW;
  localparam int IdxW  = bga_pkg::RowIdxW;
  localparam int LenW  = bga_pkg::LenW;

  state_e state_q;

  logic [bga_pkg::CfgW-1:0]   gap_open_q, gap_ext_q;
  logic [LenW-1:0]            len_a_q, len_b_q, i_q;
  logic signed [bga_pkg::BandW-1:0] bl_q, bh_q;
  logic signed [DiagW-1:0]    low_q, up_q;
  logic [IdxW-1:0]            left_q, right_q, k_q;
  logic                       first_q, sub_ok_q, done_q, status_q;
  logic signed [AccW-1:0]     t_q, sk_q, cprev_q, e_q;
  logic [bga_pkg::ScoreW-1:0] acc_q, score_q;

  // Memories and their registered read data
  logic [bga_pkg::TblW-1:0]   tbl_mem [bga_pkg::TblDepth];
  logic [bga_pkg::SymW-1:0]   a_mem   [bga_pkg::MaxLen];
  logic [bga_pkg::SymW-1:0]   b_mem   [bga_pkg::MaxLen];
  logic [AccW-1:0]            s_mem   [bga_pkg::RowDepth];
  logic [AccW-1:0]            g_mem   [bga_pkg::RowDepth];
  logic [bga_pkg::TblW-1:0]   tbl_rd_q;
  logic [bga_pkg::SymW-1:0]   a_rd_q, b_rd_q;
  logic signed [AccW-1:0]     s_rd_q, g_rd_q;

  logic                       accept, is_start, pos_ok, tbl_wr_ok;
  logic [bga_pkg::SeqAddrW-1:0] load_addr, a_raddr, b_raddr;
  logic                       a_re, b_re, tbl_re, row_re, row_we;
  logic [IdxW-1:0]            row_raddr, row_waddr;
  logic signed [AccW-1:0]     row_s_wd, row_g_wd, init_s, init_g;
  logic signed [AccW-1:0]     g_v, h_v, m_v, tbl_ext;
  logic signed [DiagW-1:0]    col_v, thr_v, i_s, left_v;
  logic                       col_ok, sym_ok;
  logic [LenW-1:0]            pen_len;
  logic [bga_pkg::CfgW+LenW-1:0] pen_prod;
  logic [bga_pkg::ScoreW-1:0] neg_pen, tbl_acc;
  bga_pkg::clamp_t            clamp;
  bga_pkg::cell_in_t          cell_in;
  bga_pkg::cell_out_t         cell_out;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign is_start = (bga_pkg::req_type_e'(req_i.req_type) == bga_pkg::REQ_START);

  // Decode load beats
  assign pos_ok    = (req_i.position >= LenW'(1)) &&
                     (req_i.position <= LenW'(bga_pkg::MaxLen));
  assign load_addr = bga_pkg::SeqAddrW'(req_i.position - LenW'(1));
  assign tbl_wr_ok = (req_i.table_row < bga_pkg::SymW'(bga_pkg::Alphabet)) &&
                     (req_i.table_col < bga_pkg::SymW'(bga_pkg::Alphabet));

  // Gap terms widened
  assign g_v = $signed({{(AccW-bga_pkg::CfgW){1'b0}}, gap_open_q});
  assign h_v = $signed({{(AccW-bga_pkg::CfgW){1'b0}}, gap_ext_q});
  assign m_v = g_v + h_v;

  // Empty sequence penalty
  assign pen_len  = (len_b_q == '0) ? len_a_q : len_b_q;
  assign pen_prod = gap_ext_q * pen_len;
  assign neg_pen  = '0 - ({{(bga_pkg::ScoreW-bga_pkg::CfgW){1'b0}}, gap_open_q} +
                    {{(bga_pkg::ScoreW-bga_pkg::CfgW-LenW){1'b0}}, pen_prod});

  // Column of cell k in row i
  assign i_s    = $signed({{(DiagW-LenW){1'b0}}, i_q});
  assign col_v  = $signed({{(DiagW-IdxW){1'b0}}, k_q}) + low_q + i_s - $signed(DiagW'(1));
  assign col_ok = (col_v > 0);
  assign thr_v  = $signed({{(DiagW-LenW){1'b0}}, len_b_q}) - up_q;
  assign left_v = $signed(DiagW'(1)) - clamp.low;

  // Substitution lookup: symbols outside the alphabet score zero
  assign sym_ok  = (a_rd_q < bga_pkg::SymW'(bga_pkg::Alphabet)) &&
                   (b_rd_q < bga_pkg::SymW'(bga_pkg::Alphabet));
  assign tbl_ext = sub_ok_q ? {{(AccW-bga_pkg::TblW){tbl_rd_q[bga_pkg::TblW-1]}}, tbl_rd_q}
                            : '0;
  assign tbl_acc = sub_ok_q ?
                   {{(bga_pkg::ScoreW-bga_pkg::TblW){tbl_rd_q[bga_pkg::TblW-1]}}, tbl_rd_q}
                   : '0;

  // Row initial contents
  always_comb begin
    if (k_q == left_q - IdxW'(1)) begin
      init_s = bga_pkg::NegFloor;
      init_g = '0;
    end else if (k_q == left_q) begin
      init_s = '0;
      init_g = -g_v;
    end else if ((k_q > left_q) && (k_q <= right_q)) begin
      init_s = t_q;
      init_g = t_q - g_v;
    end else if (k_q == right_q + IdxW'(1)) begin
      init_s = bga_pkg::NegFloor;
      init_g = bga_pkg::NegFloor;
    end else begin
      init_s = '0;
      init_g = '0;
    end
  end

  // Memory ports steered by the sequencer
  always_comb begin
    a_re      = (state_q == S_ROW) || (state_q == S_DRD);
    b_re      = (state_q == S_RD) || (state_q == S_DRD);
    tbl_re    = (state_q == S_TB) || (state_q == S_DTB);
    row_re    = (state_q == S_RDK) || (state_q == S_RD);
    row_we    = (state_q == S_INIT) || (state_q == S_CMP);
    a_raddr   = bga_pkg::SeqAddrW'(i_q - LenW'(1));
    b_raddr   = (state_q == S_DRD) ? bga_pkg::SeqAddrW'(i_q - LenW'(1))
                                   : bga_pkg::SeqAddrW'(col_v - $signed(DiagW'(1)));
    row_raddr = (state_q == S_RDK) ? left_q : k_q + IdxW'(1);
    row_waddr = k_q;
    row_s_wd  = (state_q == S_INIT) ? init_s : cell_out.c;
    row_g_wd  = (state_q == S_INIT) ? init_g : cell_out.d;
  end

  // Substitution table
  always_ff @(posedge clk_i) begin
    if (accept && (bga_pkg::req_type_e'(req_i.req_type) == bga_pkg::REQ_TABLE) && tbl_wr_ok) begin
      tbl_mem[{req_i.table_row, req_i.table_col}] <= req_i.table_value;
    end
    if (tbl_re) begin
      tbl_rd_q <= tbl_mem[{a_rd_q, b_rd_q}];
    end
  end

  // Sequence stores
  always_ff @(posedge clk_i) begin
    if (accept && (bga_pkg::req_type_e'(req_i.req_type) == bga_pkg::REQ_LOAD_A) && pos_ok) begin
      a_mem[load_addr] <= req_i.symbol;
    end
    if (accept && (bga_pkg::req_type_e'(req_i.req_type) == bga_pkg::REQ_LOAD_B) && pos_ok) begin
      b_mem[load_addr] <= req_i.symbol;
    end
    if (a_re) begin
      a_rd_q <= a_mem[a_raddr];
    end
    if (b_re) begin
      b_rd_q <= b_mem[b_raddr];
    end
  end

  // Score and gap rows
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      s_mem[row_waddr] <= row_s_wd;
      g_mem[row_waddr] <= row_g_wd;
    end
    if (row_re) begin
      s_rd_q <= s_mem[row_raddr];
      g_rd_q <= g_mem[row_raddr];
    end
  end

  bga_clamp u_clamp (
    .len_a_i     (len_a_q),
    .len_b_i     (len_b_q),
    .band_low_i  (bl_q),
    .band_high_i (bh_q),
    .clamp_o     (clamp)
  );

  assign cell_in.sk     = sk_q;
  assign cell_in.s1     = s_rd_q;
  assign cell_in.g1     = g_rd_q;
  assign cell_in.cprev  = cprev_q;
  assign cell_in.e      = e_q;
  assign cell_in.sub    = tbl_ext;
  assign cell_in.g      = g_v;
  assign cell_in.h      = h_v;
  assign cell_in.m      = m_v;
  assign cell_in.first  = first_q;
  assign cell_in.col_ok = col_ok;

  bga_cell u_cell (
    .cell_i (cell_in),
    .cell_o (cell_out)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      gap_open_q <= '0;
      gap_ext_q  <= '0;
      done_q     <= 1'b0;
      status_q   <= 1'b0;
      score_q    <= '0;
      len_a_q    <= '0;
      len_b_q    <= '0;
      bl_q       <= '0;
      bh_q       <= '0;
      low_q      <= '0;
      up_q       <= '0;
      left_q     <= '0;
      right_q    <= '0;
      k_q        <= '0;
      i_q        <= '0;
      first_q    <= 1'b0;
      sub_ok_q   <= 1'b0;
      t_q        <= '0;
      sk_q       <= '0;
      cprev_q    <= '0;
      e_q        <= '0;
      acc_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (bga_pkg::cfg_idx_e'(cfg_idx_i))
          bga_pkg::CFG_GAP_OPEN:   gap_open_q <= cfg_data_i;
          bga_pkg::CFG_GAP_EXTEND: gap_ext_q  <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        // Drop the result strobe, take a start beat
        S_IDLE: begin
          done_q <= 1'b0;
          if (accept && is_start) begin
            len_a_q <= req_i.len_a;
            len_b_q <= req_i.len_b;
            bl_q    <= req_i.band_low;
            bh_q    <= req_i.band_high;
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (clamp.oversize) begin
            status_q <= 1'b1;
            score_q  <= '0;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else if (len_b_q == '0) begin
            status_q <= 1'b0;
            score_q  <= (len_a_q != '0) ? neg_pen : '0;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else if (len_a_q == '0) begin
            status_q <= 1'b0;
            score_q  <= neg_pen;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else if (clamp.band <= $signed(DiagW'(1))) begin
            status_q <= 1'b0;
            i_q      <= LenW'(1);
            acc_q    <= '0;
            state_q  <= S_DRD;
          end else if (clamp.band > $signed(DiagW'(bga_pkg::MaxBand))) begin
            status_q <= 1'b1;
            score_q  <= '0;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            status_q <= 1'b0;
            low_q    <= clamp.low;
            up_q     <= clamp.up;
            left_q   <= left_v[IdxW-1:0];
            right_q  <= clamp.band[IdxW-1:0];
            k_q      <= '0;
            t_q      <= -g_v - h_v;
            state_q  <= S_INIT;
          end
        end
        // Fill both rows, one entry a cycle
        S_INIT: begin
          if ((k_q > left_q) && (k_q <= right_q)) begin
            t_q <= t_q - h_v;
          end
          if (k_q == IdxW'(bga_pkg::RowDepth - 1)) begin
            i_q     <= LenW'(1);
            state_q <= S_ROW;
          end else begin
            k_q <= k_q + IdxW'(1);
          end
        end
        // Shrink the band edges for this row, fetch A symbol
        S_ROW: begin
          if (i_s > thr_v) begin
            right_q <= right_q - IdxW'(1);
          end
          if (left_q > IdxW'(1)) begin
            left_q <= left_q - IdxW'(1);
          end
          state_q <= S_RDK;
        end
        S_RDK: begin
          k_q     <= left_q;
          first_q <= 1'b1;
          state_q <= S_RD;
        end
        S_RD: begin
          if (first_q) begin
            sk_q <= s_rd_q;
          end
          state_q <= S_TB;
        end
        S_TB: begin
          sub_ok_q <= sym_ok;
          state_q  <= S_CMP;
        end
        // Commit one cell, advance along the row
        S_CMP: begin
          sk_q    <= s_rd_q;
          cprev_q <= cell_out.c;
          e_q     <= cell_out.e;
          first_q <= 1'b0;
          if (k_q < right_q) begin
            k_q     <= k_q + IdxW'(1);
            state_q <= S_RD;
          end else if (i_q == len_a_q) begin
            score_q <= cell_out.c[bga_pkg::ScoreW-1:0];
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            i_q     <= i_q + LenW'(1);
            state_q <= S_ROW;
          end
        end
        // Single diagonal: sum table entries along it
        S_DRD: begin
          state_q <= S_DTB;
        end
        S_DTB: begin
          sub_ok_q <= sym_ok;
          state_q  <= S_DACC;
        end
        S_DACC: begin
          acc_q <= acc_q + tbl_acc;
          if (i_q == len_a_q) begin
            score_q <= acc_q + tbl_acc;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            i_q     <= i_q + LenW'(1);
            state_q <= S_DRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign result_o.score  = score_q;
  assign result_o.status = status_q;

  // Results are single strobes, never back to back
  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held two cycles");

  // A flagged result carries a zero score
  a_flag_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q) |-> (score_q == '0)) else $error("flagged result with score");

  // Row writes stay inside the row store
  a_row_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_we |-> (row_waddr < IdxW'(bga_pkg::RowDepth))) else $error("row write out of range");

  // A start beat makes the block busy
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_start) |=> busy) else $error("start beat not taken");

endmodule

/* hdl/bga_clamp.sv */
module bga_clamp (
  input  logic [bga_pkg::LenW-1:0]         len_a_i,
  input  logic [bga_pkg::LenW-1:0]         len_b_i,
  input  logic signed [bga_pkg::BandW-1:0] band_low_i,
  input  logic signed [bga_pkg::BandW-1:0] band_high_i,
  output bga_pkg::clamp_t                  clamp_o
);

  logic signed [bga_pkg::DiagW-1:0] ms, ns, nm, neg_m, bl, bh;
  logic signed [bga_pkg::DiagW-1:0] lo_a, lo_b, lo_v, hi_a, hi_b, up_v;

  // Widen operands
  assign ms = $signed({{(bga_pkg::DiagW-bga_pkg::LenW){1'b0}}, len_a_i});
  assign ns = $signed({{(bga_pkg::DiagW-bga_pkg::LenW){1'b0}}, len_b_i});
  assign bl = {{(bga_pkg::DiagW-bga_pkg::BandW){band_low_i[bga_pkg::BandW-1]}}, band_low_i};
  assign bh = {{(bga_pkg::DiagW-bga_pkg::BandW){band_high_i[bga_pkg::BandW-1]}}, band_high_i};
  assign nm    = ns - ms;
  assign neg_m = -ms;

  // Keep diagonal 0 and the end diagonal inside the band, stay in the matrix
  always_comb begin
    lo_a = (bl > neg_m) ? bl : neg_m;
    lo_b = (nm < 0) ? nm : '0;
    lo_v = (lo_a < lo_b) ? lo_a : lo_b;
    hi_a = (bh < ns) ? bh : ns;
    hi_b = (nm > 0) ? nm : '0;
    up_v = (hi_a > hi_b) ? hi_a : hi_b;
  end

  assign clamp_o.oversize = (len_a_i > bga_pkg::LenW'(bga_pkg::MaxLen)) ||
                            (len_b_i > bga_pkg::LenW'(bga_pkg::MaxLen));
  assign clamp_o.low  = lo_v;
  assign clamp_o.up   = up_v;
  assign clamp_o.band = up_v - lo_v + $signed(bga_pkg::DiagW'(1));

endmodule

/* hdl/bga_cell.sv */
module bga_cell (
  input  bga_pkg::cell_in_t  cell_i,
  output bga_pkg::cell_out_t cell_o
);

  logic signed [bga_pkg::AccW-1:0] c_up, d_up, d_v, diag, e_gen, e_a, e_b;
  logic signed [bga_pkg::AccW-1:0] best_de, c_v, e_v;

  // Evaluate one Gotoh cell: vertical gap, horizontal gap, diagonal
  always_comb begin
    c_up  = cell_i.s1 - cell_i.m;
    d_up  = cell_i.g1 - cell_i.h;
    d_v   = (c_up > d_up) ? c_up : d_up;
    diag  = cell_i.sk + cell_i.sub;
    e_a   = cell_i.cprev - cell_i.m;
    e_b   = cell_i.e - cell_i.h;
    e_gen = (e_a > e_b) ? e_a : e_b;
    best_de = (e_gen > d_v) ? e_gen : d_v;
    if (cell_i.first) begin
      // leftmost cell of a row has no horizontal gap
      c_v = (!cell_i.col_ok || (d_v > diag)) ? d_v : diag;
      e_v = c_v - cell_i.g;
    end else begin
      c_v = ((diag < d_v) || (diag < e_gen)) ? best_de : diag;
      e_v = e_gen;
    end
  end

  assign cell_o.c = c_v;
  assign cell_o.d = d_v;
  assign cell_o.e = e_v;

endmodule
